FILE: hw/rtl/scache_pkg.sv
// ----------------------------------------------------------------------------
// scache_pkg
// Shared sizes, codes and types of the sector cache tag/LRU engine.
// ----------------------------------------------------------------------------
`default_nettype none

package scache_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int SEC_W   = 32;
  localparam int STAMP_W = 32;
  localparam int OP_W    = 2;
  localparam int WORD_W  = SEC_W + STAMP_W;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [SEC_W-1:0]   sector_t;
  typedef logic [STAMP_W-1:0] stamp_t;

  localparam op_t OP_READ  = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_FLUSH = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_DONE    = 6'b000100,
    S_FL_RD   = 6'b001000,
    S_FL_EMIT = 6'b010000,
    S_RESP    = 6'b100000
  } state_t;

  // control from the sequencer to the scan datapath
  typedef struct packed {
    logic clear;
    logic sample;
    idx_t idx;
    logic ent_valid;
  } scan_ctl_t;

  // outcome of a full scan
  typedef struct packed {
    logic    hit;
    idx_t    hit_idx;
    logic    free;
    idx_t    open_idx;
    logic    lru;
    idx_t    lru_idx;
    sector_t lru_sector;
  } scan_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scache_if.sv
// ----------------------------------------------------------------------------
// scache_if
// Valid/ready channels of the sector cache engine: request and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface scache_in_if;
  logic                       valid;
  logic                       ready;
  logic [scache_pkg::OP_W-1:0]    operation;
  logic [scache_pkg::SEC_W-1:0]   sector;
  logic [scache_pkg::STAMP_W-1:0] now;

  modport source (output valid, operation, sector, now, input ready);
  modport sink   (input valid, operation, sector, now, output ready);
endinterface

interface scache_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [scache_pkg::IDX_W-1:0]  entry_index;
  logic                          writeback_valid;
  logic [scache_pkg::SEC_W-1:0]  writeback_sector;
  logic                          fill_valid;
  logic                          last;

  modport source (output valid, hit, entry_index, writeback_valid, writeback_sector,
                  fill_valid, last, input ready);
  modport sink   (input valid, hit, entry_index, writeback_valid, writeback_sector,
                  fill_valid, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/scache_ram.sv
// ----------------------------------------------------------------------------
// scache_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scache_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/scache_scan.sv
// ----------------------------------------------------------------------------
// scache_scan
// Tag match, free-entry and LRU tracking over the stream of entries read
// from the tag/stamp RAM, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scache_scan (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire scache_pkg::scan_ctl_t         ctl,
  input  wire scache_pkg::sector_t           req_sector,
  input  wire logic [scache_pkg::WORD_W-1:0] rd_word,
  output scache_pkg::scan_res_t              res
);

  scache_pkg::scan_res_t res_r, res_nxt;
  scache_pkg::stamp_t    lru_stamp_r, lru_stamp_nxt;
  scache_pkg::sector_t   rd_sector;
  scache_pkg::stamp_t    rd_stamp;

  assign rd_sector = rd_word[scache_pkg::SEC_W-1:0];
  assign rd_stamp  = rd_word[scache_pkg::WORD_W-1:scache_pkg::SEC_W];

  always_comb begin
    res_nxt       = res_r;
    lru_stamp_nxt = lru_stamp_r;
    if (ctl.clear) begin
      res_nxt = '0;
    end else if (ctl.sample) begin
      if (ctl.ent_valid) begin
        if (rd_sector == req_sector) begin
          res_nxt.hit     = 1'b1;
          res_nxt.hit_idx = ctl.idx;
        end else if (!res_r.lru || rd_stamp < lru_stamp_r) begin
          // strict compare keeps the lowest index on equal stamps
          res_nxt.lru        = 1'b1;
          res_nxt.lru_idx    = ctl.idx;
          res_nxt.lru_sector = rd_sector;
          lru_stamp_nxt      = rd_stamp;
        end
      end else begin
        // ascending scan: the last free one seen is the highest
        res_nxt.free     = 1'b1;
        res_nxt.open_idx = ctl.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lru_stamp_r <= lru_stamp_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sector_cache_tag_lru_engine.sv
// ----------------------------------------------------------------------------
// sector_cache_tag_lru_engine
// Tag and true-LRU replacement engine of a fully associative write-back
// sector cache; tags and stamps live in one RAM, valid bits in flops.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  in_chan   | in  | valid/ready   | operation, sector, now
//  out_chan  | out | valid/ready   | hit, entry_index, writeback_valid,
//            |     |               | writeback_sector, fill_valid, last
//
//  Access: accept, a read of every entry, the RAM read data register, the scan
//  result register, then update/result; the single RAM read port walks every entry.
//  Flush: accept, then a read and an emit per valid entry and a skip per free entry
//  below the highest valid one; accept and respond when nothing is valid or for the unused opcode.
//  One request in flight; ready is high in idle, also while a result waits.
//  A full output register stalls every step that emits a result until the result is taken.
//  Reset (sync, active low) clears all valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_cache_tag_lru_engine (
  input wire logic       clk,
  input wire logic       rst_n,
  scache_in_if.sink      in_chan,
  scache_out_if.source   out_chan
);

  localparam logic [scache_pkg::ENTRIES-1:0] BIT0 = scache_pkg::ENTRIES'(1);
  localparam logic [scache_pkg::CNT_W-1:0]   CNT_END = scache_pkg::CNT_W'(scache_pkg::ENTRIES);

  scache_pkg::state_t               state_r, state_nxt;
  logic [scache_pkg::CNT_W-1:0]     ctr_r, ctr_nxt;
  logic                             rv_r, rv_nxt;
  scache_pkg::idx_t                 ridx_r, ridx_nxt;
  logic [scache_pkg::ENTRIES-1:0]   valid_r, valid_nxt;
  scache_pkg::sector_t              req_sec_r, req_sec_nxt;
  scache_pkg::stamp_t               req_now_r, req_now_nxt;

  logic                             out_vld_r, out_vld_nxt;
  logic                             out_hit_r, out_hit_nxt;
  scache_pkg::idx_t                 out_idx_r, out_idx_nxt;
  logic                             out_wbv_r, out_wbv_nxt;
  scache_pkg::sector_t              out_wbs_r, out_wbs_nxt;
  logic                             out_fill_r, out_fill_nxt;
  logic                             out_last_r, out_last_nxt;

  logic                             in_acc;
  logic                             slot_free;
  logic                             issue;
  scache_pkg::idx_t                 cidx;
  logic [scache_pkg::ENTRIES-1:0]   rest;
  scache_pkg::idx_t                 victim;

  logic                             ram_we, ram_re;
  scache_pkg::idx_t                 ram_waddr, ram_raddr;
  logic [scache_pkg::WORD_W-1:0]    ram_wdata, ram_rdata;

  scache_pkg::scan_ctl_t            scan_ctl;
  scache_pkg::scan_res_t            scan_res;

  assign in_chan.ready = (state_r == scache_pkg::S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_vld_r || out_chan.ready;
  assign cidx          = ctr_r[scache_pkg::IDX_W-1:0];
  assign issue         = (state_r == scache_pkg::S_SCAN) && (ctr_r != CNT_END);
  assign rest          = valid_r & ~(BIT0 << cidx);
  assign victim        = scan_res.hit  ? scan_res.hit_idx  :
                         scan_res.free ? scan_res.open_idx : scan_res.lru_idx;

  assign scan_ctl.clear     = in_acc;
  assign scan_ctl.sample    = rv_r;
  assign scan_ctl.idx       = ridx_r;
  assign scan_ctl.ent_valid = valid_r[ridx_r];

  scache_ram #(
    .WIDTH (scache_pkg::WORD_W),
    .DEPTH (scache_pkg::ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scache_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .req_sector (req_sec_r),
    .rd_word    (ram_rdata),
    .res        (scan_res)
  );

  always_comb begin
    state_nxt    = state_r;
    ctr_nxt      = ctr_r;
    rv_nxt       = issue;
    ridx_nxt     = cidx;
    valid_nxt    = valid_r;
    req_sec_nxt  = req_sec_r;
    req_now_nxt  = req_now_r;

    out_vld_nxt  = out_vld_r && !out_chan.ready;
    out_hit_nxt  = out_hit_r;
    out_idx_nxt  = out_idx_r;
    out_wbv_nxt  = out_wbv_r;
    out_wbs_nxt  = out_wbs_r;
    out_fill_nxt = out_fill_r;
    out_last_nxt = out_last_r;

    ram_we    = 1'b0;
    ram_waddr = victim;
    ram_wdata = {req_now_r, req_sec_r};
    ram_re    = issue;
    ram_raddr = cidx;

    unique case (state_r)
      scache_pkg::S_IDLE: begin
        if (in_acc) begin
          req_sec_nxt = in_chan.sector;
          req_now_nxt = in_chan.now;
          ctr_nxt     = '0;
          unique case (in_chan.operation) inside
            scache_pkg::OP_READ, scache_pkg::OP_WRITE: begin
              state_nxt = scache_pkg::S_SCAN;
            end
            scache_pkg::OP_FLUSH: begin
              state_nxt = (valid_r == '0) ? scache_pkg::S_RESP : scache_pkg::S_FL_RD;
            end
            default: begin
              state_nxt = scache_pkg::S_RESP;
            end
          endcase
        end
      end

      scache_pkg::S_SCAN: begin
        if (issue) begin
          ctr_nxt = ctr_r + 1'b1;
        end else if (!rv_r) begin
          state_nxt = scache_pkg::S_DONE;
        end
      end

      scache_pkg::S_DONE: begin
        if (slot_free) begin
          ram_we            = 1'b1;
          valid_nxt[victim] = 1'b1;
          out_vld_nxt       = 1'b1;
          out_hit_nxt       = scan_res.hit;
          out_idx_nxt       = victim;
          out_wbv_nxt       = !scan_res.hit && !scan_res.free;
          out_wbs_nxt       = (!scan_res.hit && !scan_res.free) ? scan_res.lru_sector : '0;
          out_fill_nxt      = !scan_res.hit;
          out_last_nxt      = 1'b1;
          state_nxt         = scache_pkg::S_IDLE;
        end
      end

      scache_pkg::S_FL_RD: begin
        if (valid_r[cidx]) begin
          ram_re    = 1'b1;
          state_nxt = scache_pkg::S_FL_EMIT;
        end else begin
          ctr_nxt = ctr_r + 1'b1;
        end
      end

      scache_pkg::S_FL_EMIT: begin
        if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_hit_nxt  = 1'b0;
          out_idx_nxt  = cidx;
          out_wbv_nxt  = 1'b1;
          out_wbs_nxt  = ram_rdata[scache_pkg::SEC_W-1:0];
          out_fill_nxt = 1'b0;
          out_last_nxt = (rest == '0);
          valid_nxt    = rest;
          ctr_nxt      = ctr_r + 1'b1;
          state_nxt    = (rest == '0) ? scache_pkg::S_IDLE : scache_pkg::S_FL_RD;
        end
      end

      scache_pkg::S_RESP: begin
        if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_hit_nxt  = 1'b0;
          out_idx_nxt  = '0;
          out_wbv_nxt  = 1'b0;
          out_wbs_nxt  = '0;
          out_fill_nxt = 1'b0;
          out_last_nxt = 1'b1;
          state_nxt    = scache_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = scache_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= scache_pkg::S_IDLE;
      ctr_r     <= '0;
      rv_r      <= 1'b0;
      valid_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ctr_r     <= ctr_nxt;
      rv_r      <= rv_nxt;
      valid_r   <= valid_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r     <= ridx_nxt;
    req_sec_r  <= req_sec_nxt;
    req_now_r  <= req_now_nxt;
    out_hit_r  <= out_hit_nxt;
    out_idx_r  <= out_idx_nxt;
    out_wbv_r  <= out_wbv_nxt;
    out_wbs_r  <= out_wbs_nxt;
    out_fill_r <= out_fill_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid            = out_vld_r;
  assign out_chan.hit              = out_hit_r;
  assign out_chan.entry_index      = out_idx_r;
  assign out_chan.writeback_valid  = out_wbv_r;
  assign out_chan.writeback_sector = out_wbs_r;
  assign out_chan.fill_valid       = out_fill_r;
  assign out_chan.last             = out_last_r;

`ifndef SYNTHESIS
  // a finished scan always names an entry to use
  a_scan_has_victim: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == scache_pkg::S_DONE |-> scan_res.hit || scan_res.free || scan_res.lru)
    else $error("scan ended with no hit, free or LRU entry");

  // updates never collide with the scan's read stream
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && (ram_re || rv_r)))
    else $error("tag RAM write overlaps an outstanding read");

  // a flush leaves every entry invalid
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == scache_pkg::S_FL_EMIT && state_nxt == scache_pkg::S_IDLE |=> valid_r == '0)
    else $error("valid bits left set after flush");

  // a hit never carries writeback or fill
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_hit_r |-> !out_wbv_r && !out_fill_r && out_last_r)
    else $error("hit transaction carries writeback or fill");
`endif

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the sector cache tag/LRU engine against a shadow copy of its tag
// store: fills, hits, LRU evictions with stamp ties, flushes and the unused
// opcode, under random bursts on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
  import scache_pkg::*;

  localparam op_t OP_UNUSED = 2'd3;

  typedef struct packed {
    logic    hit;
    idx_t    entry_index;
    logic    writeback_valid;
    sector_t writeback_sector;
    logic    fill_valid;
    logic    last;
  } tag_result_t;

  logic clk = 1'b0;
  logic rst_n;

  scache_in_if  in_chan ();
  scache_out_if out_chan ();

  sector_cache_tag_lru_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  // shadow tag store
  logic    shadow_valid  [ENTRIES];
  sector_t shadow_sector [ENTRIES];
  stamp_t  shadow_stamp  [ENTRIES];

  tag_result_t owed_results[$];

  int unsigned mismatches   = 0;
  int unsigned n_requests   = 0;
  int unsigned n_hits       = 0;
  int unsigned n_fills      = 0;
  int unsigned n_evictions  = 0;
  int unsigned n_flushes    = 0;
  int unsigned n_writebacks = 0;
  int unsigned n_checked    = 0;
  int unsigned burst_left   = 0;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i]  = 1'b0;
      shadow_sector[i] = '0;
      shadow_stamp[i]  = '0;
    end
  end

  // Applies one request to the shadow store and queues the results it owes.
  function automatic void update_shadow_tags(op_t op, sector_t sec, stamp_t stamp);
    int          last_valid;
    int          open_idx;
    int          lru_idx;
    stamp_t      lru_stamp;
    int          victim;
    tag_result_t r;
    last_valid = -1;
    open_idx   = -1;
    lru_idx    = -1;
    lru_stamp  = '0;
    r          = '0;
    if (op == OP_FLUSH) begin
      n_flushes++;
      for (int i = 0; i < ENTRIES; i++)
        if (shadow_valid[i]) last_valid = i;
      if (last_valid < 0) begin
        r.last = 1'b1;
        owed_results.push_back(r);
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_valid[i]) begin
            r.entry_index      = idx_t'(i);
            r.writeback_valid  = 1'b1;
            r.writeback_sector = shadow_sector[i];
            r.last             = (i == last_valid);
            owed_results.push_back(r);
            n_writebacks++;
          end
        end
      end
      for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
      return;
    end
    if (op == OP_UNUSED) begin
      r.last = 1'b1;
      owed_results.push_back(r);
      return;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i]) begin
        if (shadow_sector[i] == sec) begin
          shadow_stamp[i] = stamp;
          r.hit         = 1'b1;
          r.entry_index = idx_t'(i);
          r.last        = 1'b1;
          owed_results.push_back(r);
          n_hits++;
          return;
        end
        if (lru_idx < 0 || shadow_stamp[i] < lru_stamp) begin
          lru_idx   = i;
          lru_stamp = shadow_stamp[i];
        end
      end else begin
        open_idx = i;
      end
    end
    if (open_idx >= 0) begin
      victim = open_idx;
    end else begin
      victim             = lru_idx;
      r.writeback_valid  = 1'b1;
      r.writeback_sector = shadow_sector[victim];
      n_evictions++;
    end
    shadow_valid[victim]  = 1'b1;
    shadow_sector[victim] = sec;
    shadow_stamp[victim]  = stamp;
    r.entry_index = idx_t'(victim);
    r.fill_valid  = 1'b1;
    r.last        = 1'b1;
    owed_results.push_back(r);
    n_fills++;
  endfunction

  // Sender: bursts of random length, random gaps between them.
  task automatic send_request(input op_t op, input sector_t sec, input stamp_t stamp);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 20)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end else begin
      @(negedge clk);
    end
    in_chan.valid     = 1'b1;
    in_chan.operation = op;
    in_chan.sector    = sec;
    in_chan.now       = stamp;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    update_shadow_tags(op, sec, stamp);
    n_requests++;
    burst_left--;
    if (burst_left == 0) begin
      @(negedge clk);
      in_chan.valid = 1'b0;
    end
  endtask

  task automatic wait_results_done();
    if (in_chan.valid) begin
      @(negedge clk);
      in_chan.valid = 1'b0;
    end
    burst_left = 0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: ready follows a 32-bit pattern, redrawn every three rotations.
  logic [31:0] stall_pattern = '1;
  int unsigned pattern_pos   = 0;

  always @(negedge clk) begin
    if (pattern_pos == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern = '1;
        1:       stall_pattern = $urandom | 32'h1;
        2:       stall_pattern = $urandom | $urandom | 32'h1;
        default: stall_pattern = ($urandom & $urandom) | 32'h1;
      endcase
    end
    out_chan.ready = stall_pattern[pattern_pos % 32];
    pattern_pos    = (pattern_pos + 1) % 96;
  end

  // Result checker
  always @(posedge clk) begin
    tag_result_t got;
    tag_result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.hit              = out_chan.hit;
      got.entry_index      = out_chan.entry_index;
      got.writeback_valid  = out_chan.writeback_valid;
      got.writeback_sector = out_chan.writeback_sector;
      got.fill_valid       = out_chan.fill_valid;
      got.last             = out_chan.last;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result transaction: %s%0b idx=%0d wb=%0b/%h fill=%0b last=%0b",
                   $realtime, "hit=", got.hit, got.entry_index, got.writeback_valid,
                   got.writeback_sector, got.fill_valid, got.last);
      end else begin
        want = owed_results.pop_front();
        n_checked++;
        if (got.hit !== want.hit || got.entry_index !== want.entry_index ||
            got.writeback_valid !== want.writeback_valid ||
            got.writeback_sector !== want.writeback_sector ||
            got.fill_valid !== want.fill_valid || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result mismatch", $realtime);
            $display("  expected: hit=%0b idx=%0d wb=%0b/%h fill=%0b last=%0b",
                     want.hit, want.entry_index, want.writeback_valid,
                     want.writeback_sector, want.fill_valid, want.last);
            $display("  actual:   hit=%0b idx=%0d wb=%0b/%h fill=%0b last=%0b",
                     got.hit, got.entry_index, got.writeback_valid,
                     got.writeback_sector, got.fill_valid, got.last);
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------ tests

  task automatic test_empty_flush();
    send_request(OP_FLUSH, $urandom, $urandom);
    send_request(OP_UNUSED, '1, '1);
  endtask

  task automatic test_fill_hit_extremes();
    send_request(OP_READ,  32'h0000_0000, 32'h0000_0000);
    send_request(OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_READ,  32'h0000_0000, 32'h0000_0005);  // hit
    send_request(OP_WRITE, 32'hFFFF_FFFF, 32'h0000_0000);  // hit, stamp refresh
    send_request(OP_READ,  32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_UNUSED, 32'h8000_0000, 32'h1234_5678); // no state change
    send_request(OP_WRITE, 32'h8000_0000, 32'h0000_0010);  // still a hit
    send_request(OP_READ,  32'h5555_AAAA, 32'hAAAA_5555);
  endtask

  task automatic test_flush_valid();
    send_request(OP_FLUSH, '0, '0);        // writes back four entries
    send_request(OP_FLUSH, '1, '1);        // nothing left to write back
    send_request(OP_READ,  32'h5555_AAAA, 32'h0000_0001);  // refill after flush
    send_request(OP_UNUSED, '0, '0);
  endtask

  // Fill every entry with clustered stamps so ties occur, then evict.
  task automatic test_lru_replacement();
    sector_t filled[$];
    sector_t sec;
    for (int i = 0; i < ENTRIES; i++) begin
      sec = $urandom;
      filled.push_back(sec);
      send_request(($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ, sec,
                   (i == 5) ? 32'hFFFF_FFFF : stamp_t'($urandom_range(1, 6)));
    end
    for (int i = 0; i < 3; i++)
      send_request(OP_READ, filled[$urandom_range(1, ENTRIES - 1)], '0);
    for (int i = 0; i < 12; i++)
      send_request(OP_WRITE, $urandom, stamp_t'(8 + i / 2));
    // hold off until the engine has drained everything
    wait_results_done();
  endtask

  // Accesses drawn from a working set around the entry count, so hits,
  // fills and evictions mix; occasional flushes, unused opcodes and noise.
  task automatic test_random_traffic(input int unsigned n_items);
    sector_t     pool[96];
    int unsigned pool_size;
    stamp_t      tick;
    stamp_t      stamp;
    sector_t     sec;
    op_t         op;
    int unsigned roll;
    tick      = $urandom;
    pool_size = 64;
    for (int i = 0; i < 96; i++) pool[i] = $urandom;
    pool[0] = '0;
    pool[1] = '1;
    for (int unsigned n = 0; n < n_items; n++) begin
      if (n % 50 == 0) pool_size = $urandom_range(40, 96);
      roll = $urandom_range(0, 99);
      sec  = pool[$urandom_range(0, pool_size - 1)];
      if (roll < 45)      op = OP_READ;
      else if (roll < 90) op = OP_WRITE;
      else if (roll < 94) op = OP_FLUSH;
      else if (roll < 96) op = OP_UNUSED;
      else begin
        op  = op_t'($urandom_range(0, 1));
        sec = $urandom;
      end
      tick  = tick + stamp_t'($urandom_range(0, 3));
      stamp = ($urandom_range(0, 19) == 0) ? stamp_t'($urandom) : tick;
      send_request(op, sec, stamp);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.operation = OP_READ;
    in_chan.sector    = '0;
    in_chan.now       = '0;
    out_chan.ready    = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_empty_flush();
    test_fill_hit_extremes();
    test_flush_valid();
    test_lru_replacement();
    test_random_traffic(400);

    wait_results_done();
    repeat (200) @(posedge clk);
    $display("%0d requests, %0d result transactions checked", n_requests, n_checked);
    $display("%0d hits, %0d fills, %0d evictions, %0d flushes writing back %0d entries",
             n_hits, n_fills, n_evictions, n_flushes, n_writebacks);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout with %0d results outstanding", owed_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule
